[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file sfz_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define SFZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is low
`define SFZ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/sfz_pkg.sv]
// ----------------------------------------------------------------------------
// sfz_pkg
// Types, codes and FiO2 clamp helpers for the SpO2/FiO2 zone controller.
// ----------------------------------------------------------------------------
package sfz_pkg;

	localparam int PCT_W     = 7;
	localparam int STATUS_W  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FORCE  = 2'd1,
		OP_LOAD   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TMR_NONE    = 2'd0,
		TMR_ENABLE  = 2'd1,
		TMR_DISABLE = 2'd2
	} tmr_t;

	localparam logic [STATUS_W-1:0] ST_MIDDLE     = 4'd0;
	localparam logic [STATUS_W-1:0] ST_MIDLOW     = 4'd1;
	localparam logic [STATUS_W-1:0] ST_MIDHIGH    = 4'd2;
	localparam logic [STATUS_W-1:0] ST_LOW1       = 4'd3;
	localparam logic [STATUS_W-1:0] ST_LOW2       = 4'd4;
	localparam logic [STATUS_W-1:0] ST_HIGH1      = 4'd5;
	localparam logic [STATUS_W-1:0] ST_HIGH2      = 4'd6;
	localparam logic [STATUS_W-1:0] ST_LOWALARM1  = 4'd7;
	localparam logic [STATUS_W-1:0] ST_HIGHALARM1 = 4'd8;
	localparam logic [STATUS_W-1:0] ST_ALARM      = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_SPO2_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPO2_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPO2_MID  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIO2_FLR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIO2_CEIL = 3'd4;

	localparam logic [PCT_W-1:0] RST_SPO2_LOW  = 7'd88;
	localparam logic [PCT_W-1:0] RST_SPO2_HIGH = 7'd95;
	localparam logic [PCT_W-1:0] RST_SPO2_MID  = 7'd91;
	localparam logic [PCT_W-1:0] RST_FIO2_FLR  = 7'd21;
	localparam logic [PCT_W-1:0] RST_FIO2_CEIL = 7'd100;
	localparam logic [PCT_W-1:0] RST_FIO2      = 7'd21;

	localparam logic [PCT_W:0] FAR_MARGIN = 8'd3;
	localparam logic [PCT_W:0] STEP_FAR   = 8'd6;
	localparam logic [PCT_W:0] STEP_NEAR  = 8'd4;
	localparam logic [PCT_W:0] STEP_MID   = 8'd2;
	localparam logic [PCT_W:0] STEP_ZERO  = 8'd0;

	typedef struct packed {
		logic [PCT_W-1:0] spo2_low;
		logic [PCT_W-1:0] spo2_high;
		logic [PCT_W-1:0] spo2_mid;
		logic [PCT_W-1:0] fio2_floor;
		logic [PCT_W-1:0] fio2_ceiling;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PCT_W-1:0]    fio2;
		logic [PCT_W-1:0]    baseline;
	} state_t;

	typedef struct packed {
		op_t                 opcode;
		logic [PCT_W-1:0]    spo2_sample;
		logic [STATUS_W-1:0] forced_status;
		logic [PCT_W-1:0]    fio2_load_value;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] zone_status;
		logic [PCT_W-1:0]    fio2_target;
		logic [PCT_W-1:0]    baseline_spo2;
		logic                valve_update;
		tmr_t                timer_command;
		logic                clear_alarm_time;
		logic                clear_respond_time;
	} result_t;

	function automatic logic [PCT_W-1:0] clamp_up(input logic [PCT_W-1:0] cur,
		input logic [PCT_W:0] delta, input logic [PCT_W-1:0] ceil_v);
		logic [PCT_W:0] sum;
		sum = {1'b0, cur} + delta;
		return (sum > {1'b0, ceil_v}) ? ceil_v : sum[PCT_W-1:0];
	endfunction

	function automatic logic [PCT_W-1:0] clamp_down(input logic [PCT_W-1:0] cur,
		input logic [PCT_W:0] delta, input logic [PCT_W-1:0] floor_v);
		logic [PCT_W:0] diff;
		diff = {1'b0, cur} - delta;
		return ({1'b0, cur} < ({1'b0, floor_v} + delta)) ? floor_v : diff[PCT_W-1:0];
	endfunction

endpackage

[rtl/spo2_fio2_zone_controller.sv]
// ----------------------------------------------------------------------------
// spo2_fio2_zone_controller
// SpO2 zone classifier and FiO2 target stepper with alarm timer commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser carries the opcode (sample, force status,
//   load FiO2, none); s_tdata carries the sample, forced status and load value.
//   Output stream m_*: one transaction per accepted input, carrying the zone
//   status, FiO2 target, baseline SpO2, valve update, timer command and the
//   two counter clears.
//   Configuration: cfg_we writes cfg_wdata into the register at cfg_index
//   (0 low limit, 1 high limit, 2 mid point, 3 FiO2 floor, 4 FiO2 ceiling);
//   write only while no transaction is in flight.
//   Path: an accepted input is held in the input register, then in the
//   result register, from which it is offered.
//   Throughput: one item per cycle while the output is not stalled; the zone
//   decision and clamped step fit between the input register and the result
//   register, and the state registers update in the same cycle the result is loaded.
//   Reset: status middle, FiO2 target 21, baseline 0, limits to defaults,
//   both streams empty.
//   Stall: while m_tready is low the result holds, the input register keeps
//   one more item, then s_tready drops.
// ----------------------------------------------------------------------------
module spo2_fio2_zone_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [6:0] spo2_sample, [10:7] forced_status, [17:11] fio2_load_value, [23:18] zero
	input  logic [sfz_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] opcode
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [3:0] zone_status, [10:4] fio2_target, [17:11] baseline_spo2,
	// [18] valve_update, [20:19] timer_command, [21] clear_alarm_time,
	// [22] clear_respond_time, [23] zero
	output logic [sfz_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic [sfz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfz_pkg::PCT_W-1:0]      cfg_wdata
);
	import sfz_pkg::*;

	cfg_t    cfg;
	item_t   item_in, item_s1;
	logic    valid_s1;
	state_t  state_q, state_nxt;
	result_t res, out_q;
	logic    out_valid_q;
	logic    advance, accept, process;

	sfz_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign item_in.opcode          = op_t'(s_tuser);
	assign item_in.spo2_sample     = s_tdata[6:0];
	assign item_in.forced_status   = s_tdata[10:7];
	assign item_in.fio2_load_value = s_tdata[17:11];

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign process  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= item_in;
	end

	sfz_zone_logic u_zone (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.status   <= ST_MIDDLE;
			state_q.fio2     <= RST_FIO2;
			state_q.baseline <= '0;
			out_valid_q      <= 1'b0;
		end else if (process) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.clear_respond_time, out_q.clear_alarm_time,
		out_q.timer_command, out_q.valve_update, out_q.baseline_spo2,
		out_q.fio2_target, out_q.zone_status};

endmodule

[rtl/sfz_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sfz_cfg_regs
// Limit and FiO2 bound registers behind the write-only configuration port.
// ----------------------------------------------------------------------------
module sfz_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfz_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfz_pkg::PCT_W-1:0]     cfg_wdata,
	output sfz_pkg::cfg_t                 cfg
);
	import sfz_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spo2_low     <= RST_SPO2_LOW;
			cfg_q.spo2_high    <= RST_SPO2_HIGH;
			cfg_q.spo2_mid     <= RST_SPO2_MID;
			cfg_q.fio2_floor   <= RST_FIO2_FLR;
			cfg_q.fio2_ceiling <= RST_FIO2_CEIL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPO2_LOW:  cfg_q.spo2_low     <= cfg_wdata;
				REG_SPO2_HIGH: cfg_q.spo2_high    <= cfg_wdata;
				REG_SPO2_MID:  cfg_q.spo2_mid     <= cfg_wdata;
				REG_FIO2_FLR:  cfg_q.fio2_floor   <= cfg_wdata;
				REG_FIO2_CEIL: cfg_q.fio2_ceiling <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/sfz_zone_logic.sv]
// ----------------------------------------------------------------------------
// sfz_zone_logic
// Zone classification, clamped FiO2 step and command decode for one item.
// ----------------------------------------------------------------------------
module sfz_zone_logic (
	input  sfz_pkg::item_t   item,
	input  sfz_pkg::cfg_t    cfg,
	input  sfz_pkg::state_t  cur,
	output sfz_pkg::state_t  nxt,
	output sfz_pkg::result_t res
);
	import sfz_pkg::*;

	logic [PCT_W:0] s8, lo8, hi8, mid8;
	logic           alarm, below, above, inband;
	logic           far_below, far_above;

	assign s8     = {1'b0, item.spo2_sample};
	assign lo8    = {1'b0, cfg.spo2_low};
	assign hi8    = {1'b0, cfg.spo2_high};
	assign mid8   = {1'b0, cfg.spo2_mid};
	assign alarm  = (cur.status == ST_ALARM);
	assign below  = (s8 < lo8) && !alarm;
	assign above  = (s8 > hi8) && !alarm;
	assign inband = (s8 >= lo8) && (s8 <= hi8);
	assign far_below = (s8 + FAR_MARGIN) < lo8;
	assign far_above = s8 > (hi8 + FAR_MARGIN);

	always_comb begin
		logic enter;
		enter = 1'b0;
		nxt   = cur;
		res.valve_update       = 1'b0;
		res.timer_command      = TMR_NONE;
		res.clear_alarm_time   = 1'b0;
		res.clear_respond_time = 1'b0;
		case (item.opcode)
			OP_FORCE: nxt.status = item.forced_status;
			OP_LOAD:  nxt.fio2   = item.fio2_load_value;
			OP_SAMPLE: begin
				if (below) begin
					if (far_below) begin
						enter = (cur.status != ST_LOW2);
						if (enter) nxt.status = ST_LOW2;
						nxt.fio2 = clamp_up(cur.fio2, enter ? STEP_FAR : STEP_ZERO,
							cfg.fio2_ceiling);
					end else begin
						enter = (cur.status != ST_LOW1) && (cur.status != ST_LOWALARM1);
						if (enter) nxt.status = ST_LOW1;
						nxt.fio2 = clamp_up(cur.fio2, enter ? STEP_NEAR : STEP_ZERO,
							cfg.fio2_ceiling);
					end
					res.valve_update = 1'b1;
				end else if (above) begin
					if (far_above) begin
						enter = (cur.status != ST_HIGH2);
						if (enter) nxt.status = ST_HIGH2;
						nxt.fio2 = clamp_down(cur.fio2, enter ? STEP_FAR : STEP_ZERO,
							cfg.fio2_floor);
					end else begin
						enter = (cur.status != ST_HIGH1) && (cur.status != ST_HIGHALARM1);
						if (enter) nxt.status = ST_HIGH1;
						nxt.fio2 = clamp_down(cur.fio2, enter ? STEP_NEAR : STEP_ZERO,
							cfg.fio2_floor);
					end
					res.valve_update = 1'b1;
				end else if (inband) begin
					res.valve_update = 1'b1;
					if (s8 < mid8) begin
						if (cur.status != ST_MIDLOW) begin
							nxt.status = ST_MIDLOW;
							nxt.fio2   = clamp_up(cur.fio2, STEP_MID, cfg.fio2_ceiling);
							res.clear_alarm_time   = 1'b1;
							res.clear_respond_time = 1'b1;
							res.timer_command      = TMR_ENABLE;
						end
					end else if (s8 > mid8) begin
						if (cur.status != ST_MIDHIGH) begin
							nxt.status   = ST_MIDHIGH;
							nxt.baseline = item.spo2_sample;
							nxt.fio2     = clamp_down(cur.fio2, STEP_MID, cfg.fio2_floor);
							res.clear_alarm_time = 1'b1;
							res.timer_command    = TMR_ENABLE;
						end
					end else begin
						nxt.status   = ST_MIDDLE;
						nxt.baseline = item.spo2_sample;
						res.clear_alarm_time   = 1'b1;
						res.clear_respond_time = 1'b1;
						res.timer_command      = TMR_DISABLE;
					end
				end
				// entry into a below or above zone
				if ((below || above) && enter) begin
					nxt.baseline = item.spo2_sample;
					res.clear_alarm_time   = 1'b1;
					res.clear_respond_time = 1'b1;
					res.timer_command      = TMR_ENABLE;
				end
			end
			default: ;
		endcase
		res.zone_status   = nxt.status;
		res.fio2_target   = nxt.fio2;
		res.baseline_spo2 = nxt.baseline;
	end

endmodule

[rtl/sfz_checker.sv]
// ----------------------------------------------------------------------------
// sfz_checker
// Port-level checks on the zone controller result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfz_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [sfz_pkg::OUT_DATA_W-1:0] m_tdata
);
	import sfz_pkg::*;

	`SFZ_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))
	`SFZ_ASSERT_IMP(a_no_valve_no_cmd, clk, arst_n, m_tvalid && !m_tdata[18],
		m_tdata[22:19] == 4'b0000)
	`SFZ_ASSERT_IMP(a_tmr_code, clk, arst_n, m_tvalid, m_tdata[20:19] != 2'b11)
	`SFZ_ASSERT_IMP(a_clr_pair, clk, arst_n, m_tvalid && m_tdata[22], m_tdata[21])
	`SFZ_ASSERT_IMP(a_disable_mid, clk, arst_n,
		m_tvalid && (m_tdata[20:19] == TMR_DISABLE), m_tdata[3:0] == ST_MIDDLE)

endmodule

bind spo2_fio2_zone_controller sfz_checker u_sfz_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
